// ===== design/delta_zigzag_varint_encoder_macros.svh =====
// Assertion macros for the delta zigzag varint encoder.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef DELTA_ZIGZAG_VARINT_ENCODER_MACROS_SVH
`define DELTA_ZIGZAG_VARINT_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DZVE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DZVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dzve_pkg.sv =====
// Shared types and constants of the delta zigzag varint encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dzve_pkg;

   localparam int unsigned ELEM_BITS  = 64;
   localparam int unsigned NARROW_BITS = 32;
   localparam int unsigned GROUP_BITS = 7;
   localparam logic [7:0]  CONT_FLAG  = 8'h80;

   typedef struct packed {
      logic signed [ELEM_BITS-1:0] element_value;
      logic                        block_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } emit_state_type;

   // Maps a signed difference so that small magnitudes give small codes.
   function automatic logic [ELEM_BITS-1:0] zigzag(input logic [ELEM_BITS-1:0] n);
      return {n[ELEM_BITS-2:0], 1'b0} ^ {ELEM_BITS{n[ELEM_BITS-1]}};
   endfunction

endpackage

`default_nettype wire

// ===== design/dzve_delta.sv =====
// Delta stage: keeps the previous element and forms the zigzag code of the difference.
// Depends on dzve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dzve_delta
   import dzve_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire req_type              req,
   input  wire logic                 wide_mode,
   output logic [ELEM_BITS-1:0]      code
);

   logic [ELEM_BITS-1:0] previous_ff;
   logic [ELEM_BITS-1:0] previous_in;
   logic [ELEM_BITS-1:0] elem_bits;
   logic [ELEM_BITS-1:0] base;
   logic [ELEM_BITS-1:0] diff_raw;
   logic [ELEM_BITS-1:0] diff;

   always_comb begin
      elem_bits = req.element_value;
      base      = req.block_start ? '0 : previous_ff;
      diff_raw  = elem_bits - base;
      // Narrow elements wrap at 32 bits and are then sign-extended.
      if (wide_mode) begin
         diff = diff_raw;
      end else begin
         diff = {{(ELEM_BITS-NARROW_BITS){diff_raw[NARROW_BITS-1]}},
                 diff_raw[NARROW_BITS-1:0]};
      end
      code        = zigzag(diff);
      previous_in = load ? elem_bits : previous_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ff <= '0;
      end else begin
         previous_ff <= previous_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/dzve_emit.sv =====
// Byte emitter: a shared 7-bit shifter under a small sequencer, plus the output register.
// Depends on dzve_pkg and delta_zigzag_varint_encoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "delta_zigzag_varint_encoder_macros.svh"

module dzve_emit
   import dzve_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic [ELEM_BITS-1:0] code,
   output logic                      busy,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload
);

   emit_state_type       state_ff;
   emit_state_type       state_in;
   logic [ELEM_BITS-1:0] shift_ff;
   logic [ELEM_BITS-1:0] shift_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 emit;
   logic                 last;

   // The final group is reached once nothing is left above the low seven bits.
   assign last = (shift_ff[ELEM_BITS-1:GROUP_BITS] == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit && last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
      emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

      if (load) begin
         shift_in = code;
      end else if (emit) begin
         shift_in = shift_ff >> GROUP_BITS;
      end else begin
         shift_in = shift_ff;
      end

      if (emit) begin
         rsp_in.out_byte  = last ? {1'b0, shift_ff[GROUP_BITS-1:0]}
                                 : (CONT_FLAG | {1'b0, shift_ff[GROUP_BITS-1:0]});
         rsp_in.last_byte = last;
         rsp_valid_in     = 1'b1;
      end else begin
         rsp_in       = rsp_ff;
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff <= shift_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `DZVE_ASSERT_NOW(a_load_only_idle, clock, reset, load, state_ff == ST_IDLE, "load while busy")
   `DZVE_ASSERT_NEXT(a_more_follow, clock, reset, emit && !last, state_ff == ST_EMIT, "dropped group")
   `DZVE_ASSERT_NEXT(a_done_idle, clock, reset, emit && last, state_ff == ST_IDLE, "stuck after last")
   `DZVE_ASSERT_NOW(a_flag_match, clock, reset, rsp_valid_ff,
                    rsp_ff.out_byte[7] == !rsp_ff.last_byte, "continuation flag mismatch")

endmodule

`default_nettype wire

// ===== design/delta_zigzag_varint_encoder.sv =====
// Delta zigzag varint encoder, top level. Depends on dzve_pkg, dzve_delta and dzve_emit.
// The first byte of a transaction passes the shift register, then the output register.
// Throughput: one byte per cycle while the output is not stalled; an element of n bytes
// (1 to 5 narrow, 1 to 10 wide) holds the input until the single shared 7-bit shifter is done.
// Reset (synchronous, active high) clears the previous element, the mode and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module delta_zigzag_varint_encoder
   import dzve_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data
);

   // Mode register: 0 selects 32-bit elements, 1 selects 64-bit elements.
   logic                 wide_mode_ff;
   logic                 wide_mode_in;
   logic                 busy;
   logic                 load;
   logic [ELEM_BITS-1:0] code;

   assign wide_mode_in = csr_wr_en ? csr_wr_data : wide_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff <= 1'b0;
      end else begin
         wide_mode_ff <= wide_mode_in;
      end
   end

   // A new transaction is taken whenever the sequencer is idle. The output
   // register keeps the last byte of the previous element on its own, so the
   // input does not wait for that byte to be taken.
   assign req_stall = busy;
   assign load      = req_valid && !busy;

   // The difference and its zigzag code are formed in the accept cycle and
   // loaded straight into the emitter's shift register.
   dzve_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .req       (req_payload),
      .wide_mode (wide_mode_ff),
      .code      (code)
   );

   // The emitter peels off one 7-bit group per cycle while the output is not stalled,
   // low group first, and sets the continuation flag on every byte but the last.
   dzve_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .code        (code),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
